FILE: rtl/ffta_pkg.sv
// Shared types and constants for the first-fit tag allocator.
// Depends on nothing; imported by the allocator top level.
package ffta_pkg;

    localparam int unsigned POOL_UNITS = 1024;
    localparam int unsigned ADDR_W     = 10;
    localparam int unsigned LEN_W      = 11;
    localparam int unsigned TAG_W      = LEN_W + 1;
    localparam int unsigned REQ_W      = 11;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [LEN_W-1:0] POOL_LEN      = LEN_W'(POOL_UNITS);
    localparam logic [REQ_W-1:0] MAX_REQ_RESET = REQ_W'(1024);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_GRANTED   = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_FREED     = 2'd3
    } t_status;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_AWALK  = 8'b0000_0100,
        S_SPLIT  = 8'b0000_1000,
        S_FHEAD  = 8'b0001_0000,
        S_FMERGE = 8'b0010_0000,
        S_FWB    = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } t_state;

endpackage

FILE: rtl/ffta_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffta_ram #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/first_fit_tag_allocator_core.sv
// First-fit boundary-tag allocator over a 1024-unit pool, tags kept in one RAM.
// Depends on ffta_pkg and ffta_ram.
//
// After reset the block runs a clearing pass over all 1024 tag RAM entries and
// accepts no item until it ends; configuration writes are taken at any time.
// An allocate item visits header tags one by one, writing a second tag when the
// chosen block is split. A free item reads its header, then each following block
// while it is free, merging it; it stops at the header when the address does not
// name a used block or the block already ends at the pool end. An oversized
// request or a free of address zero reads no tag. The walk is set by the single
// read port of the tag RAM: one tag per cycle. One item is in work at a time,
// and the next is taken while the last result waits in the output register.
module first_fit_tag_allocator_core
    import ffta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [REQ_W-1:0]      i_cfg_wdata,   // max_request_units
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [9:0] size_units, [19:10] block_addr
    input  logic                  s_axis_tuser,  // [0] cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [9:0] payload_addr
    output logic [1:0]            m_axis_tuser   // [1:0] status
);

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_h, n_h;
    logic [ADDR_W-1:0]   r_n, n_n;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic [LEN_W-1:0]    r_need, n_need;
    logic [LEN_W-1:0]    r_rem, n_rem;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [REQ_W-1:0]    r_max_req;
    t_status             r_res_status, n_res_status;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [TAG_W-1:0]    ram_wdata, ram_rdata;

    logic                tag_used;
    logic [LEN_W-1:0]    tag_len;
    logic [ADDR_W-1:0]   in_size, in_addr;
    logic [LEN_W-1:0]    in_need;
    logic [ADDR_W+1:0]   walk_sum;
    logic [LEN_W-1:0]    fit_rem;
    logic [LEN_W-1:0]    head_limit, head_end;
    logic [LEN_W-1:0]    merge_limit, merge_len, merge_end;
    logic                out_load;

    ffta_ram #(
        .WIDTH (TAG_W),
        .DEPTH (POOL_UNITS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign tag_used    = ram_rdata[TAG_W-1];
    assign tag_len     = ram_rdata[LEN_W-1:0];
    assign in_size     = s_axis_tdata[ADDR_W-1:0];
    assign in_addr     = s_axis_tdata[2*ADDR_W-1:ADDR_W];
    assign in_need     = {1'b0, in_size} + LEN_W'(1);
    assign walk_sum    = {2'b00, r_h} + {1'b0, tag_len};
    assign fit_rem     = tag_len - r_need;
    assign head_limit  = POOL_LEN - {1'b0, r_h};
    assign head_end    = {1'b0, r_h} + tag_len;
    assign merge_limit = POOL_LEN - {1'b0, r_n};
    assign merge_len   = r_len + tag_len;
    assign merge_end   = {1'b0, r_h} + merge_len;

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_load      = (r_state == S_RESP) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state      = r_state;
        n_h          = r_h;
        n_n          = r_n;
        n_clr        = r_clr;
        n_need       = r_need;
        n_rem        = r_rem;
        n_len        = r_len;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        ram_we       = 1'b0;
        ram_waddr    = r_h;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = r_h;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = (r_clr == '0) ? {1'b0, POOL_LEN} : '0;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_res_addr = '0;
                    if (t_cmd'(s_axis_tuser) == CMD_ALLOC) begin
                        if (in_need > r_max_req) begin
                            n_res_status = ST_TOO_LARGE;
                            n_state      = S_RESP;
                        end else begin
                            n_need    = in_need;
                            n_h       = '0;
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_state   = S_AWALK;
                        end
                    end else begin
                        if (in_addr == '0) begin
                            n_res_status = ST_FREED;
                            n_state      = S_RESP;
                        end else begin
                            n_h       = in_addr - ADDR_W'(1);
                            ram_re    = 1'b1;
                            ram_raddr = in_addr - ADDR_W'(1);
                            n_state   = S_FHEAD;
                        end
                    end
                end
            end
            S_AWALK: begin
                if (tag_len == '0) begin
                    n_res_status = ST_NO_SPACE;
                    n_state      = S_RESP;
                end else if (!tag_used && (tag_len >= r_need)) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_h;
                    n_res_status = ST_GRANTED;
                    n_res_addr   = r_h + ADDR_W'(1);
                    if (fit_rem >= LEN_W'(2)) begin
                        ram_wdata = {1'b1, r_need};
                        n_rem     = fit_rem;
                        n_state   = S_SPLIT;
                    end else begin
                        ram_wdata = {1'b1, tag_len};
                        n_state   = S_RESP;
                    end
                end else if (walk_sum >= (ADDR_W+2)'(POOL_UNITS)) begin
                    n_res_status = ST_NO_SPACE;
                    n_state      = S_RESP;
                end else begin
                    n_h       = walk_sum[ADDR_W-1:0];
                    ram_re    = 1'b1;
                    ram_raddr = walk_sum[ADDR_W-1:0];
                end
            end
            S_SPLIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_h + r_need[ADDR_W-1:0];
                ram_wdata = {1'b0, r_rem};
                n_state   = S_RESP;
            end
            S_FHEAD: begin
                n_res_status = ST_FREED;
                if (!tag_used || (tag_len == '0) || (tag_len > head_limit)) begin
                    n_state = S_RESP;
                end else begin
                    n_len = tag_len;
                    if (head_end >= POOL_LEN) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_h;
                        ram_wdata = {1'b0, tag_len};
                        n_state   = S_RESP;
                    end else begin
                        n_n       = head_end[ADDR_W-1:0];
                        ram_re    = 1'b1;
                        ram_raddr = head_end[ADDR_W-1:0];
                        n_state   = S_FMERGE;
                    end
                end
            end
            S_FMERGE: begin
                if (tag_used || (tag_len == '0) || (tag_len > merge_limit)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_h;
                    ram_wdata = {1'b0, r_len};
                    n_state   = S_RESP;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_n;
                    ram_wdata = '0;
                    n_len     = merge_len;
                    if (merge_end >= POOL_LEN) begin
                        n_state = S_FWB;
                    end else begin
                        n_n       = merge_end[ADDR_W-1:0];
                        ram_re    = 1'b1;
                        ram_raddr = merge_end[ADDR_W-1:0];
                    end
                end
            end
            S_FWB: begin
                ram_we    = 1'b1;
                ram_waddr = r_h;
                ram_wdata = {1'b0, r_len};
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_max_req <= MAX_REQ_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (i_cfg_we) begin
                r_max_req <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h          <= n_h;
        r_n          <= n_n;
        r_need       <= n_need;
        r_rem        <= n_rem;
        r_len        <= n_len;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_addr   <= (r_res_status == ST_GRANTED) ? r_res_addr : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W-ADDR_W)'(0), r_out_addr};
    assign m_axis_tuser  = r_out_status;

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("tag RAM read and write hit the same entry");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("item accepted during clearing pass");

    a_merge_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FMERGE) |-> (r_n > r_h))
        else $error("merge pointer not past block header");

    a_addr_zero_unless_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_GRANTED)) |-> (m_axis_tdata == '0))
        else $error("address on non-granted result");

endmodule

FILE: verif/ffta_checker.sv
// Response checker for first_fit_tag_allocator_core: keeps a mirror of the tag
// store, predicts the response to every accepted request and compares it with
// the output stream. Depends on ffta_pkg.
module ffta_checker
    import ffta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [REQ_W-1:0]      i_cfg_wdata,  // max_request_units
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [IN_DATA_W-1:0]  i_req_data,   // [9:0] size_units, [19:10] block_addr
    input  logic                  i_req_user,   // [0] cmd
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  logic [OUT_DATA_W-1:0] i_rsp_data,   // [9:0] payload_addr
    input  logic [1:0]            i_rsp_user,   // [1:0] status
    output int                    o_err_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             used;
        logic [LEN_W-1:0] len;
    } t_tag;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] payload;
    } t_response;

    t_tag             tag_mirror [POOL_UNITS];
    logic [REQ_W-1:0] max_request;
    t_response        expected_responses [$];
    int               mismatches = 0;

    function automatic t_response first_fit_alloc(input logic [ADDR_W-1:0] size);
        int unsigned need;
        int unsigned h;
        int unsigned len;
        t_response   rsp;
        need        = size + 1;
        rsp.status  = ST_NO_SPACE;
        rsp.payload = '0;
        if (need > max_request) begin
            rsp.status = ST_TOO_LARGE;
            return rsp;
        end
        h = 0;
        while (h < POOL_UNITS) begin
            len = tag_mirror[h].len;
            if (len == 0)
                break;
            if (!tag_mirror[h].used && len >= need) begin
                if (len - need >= 2) begin
                    tag_mirror[h]        = '{used: 1'b1, len: LEN_W'(need)};
                    tag_mirror[h + need] = '{used: 1'b0, len: LEN_W'(len - need)};
                end else begin
                    tag_mirror[h].used = 1'b1;
                end
                rsp.status  = ST_GRANTED;
                rsp.payload = ADDR_W'(h + 1);
                return rsp;
            end
            h += len;
        end
        return rsp;
    endfunction

    function automatic void release_and_merge(input logic [ADDR_W-1:0] addr);
        int unsigned h;
        int unsigned len;
        int unsigned n;
        int unsigned nl;
        if (addr == 0)
            return;
        h = addr - 1;
        if (!tag_mirror[h].used)
            return;
        len = tag_mirror[h].len;
        if (len == 0 || len > POOL_UNITS - h)
            return;
        n = h + len;
        while (n < POOL_UNITS) begin
            nl = tag_mirror[n].len;
            if (tag_mirror[n].used || nl == 0 || nl > POOL_UNITS - n)
                break;
            tag_mirror[n] = '0;
            len += nl;
            n = h + len;
        end
        tag_mirror[h] = '{used: 1'b0, len: LEN_W'(len)};
    endfunction

    always @(posedge i_clk) begin
        t_response got;
        t_response want;
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_UNITS; i++)
                tag_mirror[i] = '0;
            tag_mirror[0] = '{used: 1'b0, len: POOL_LEN};
            max_request   = MAX_REQ_RESET;
            expected_responses.delete();
        end else begin
            if (i_cfg_we)
                max_request = i_cfg_wdata;
            if (i_rsp_valid && i_rsp_ready) begin
                got.status  = t_status'(i_rsp_user);
                got.payload = i_rsp_data[ADDR_W-1:0];
                if (expected_responses.size() == 0) begin
                    $error("unexpected response: status %0d payload_addr %0d",
                           got.status, got.payload);
                    mismatches++;
                end else begin
                    want = expected_responses.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.payload !== want.payload) begin
                        $error("payload_addr: expected %0d, got %0d",
                               want.payload, got.payload);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (t_cmd'(i_req_user) == CMD_ALLOC) begin
                    expected_responses.push_back(first_fit_alloc(i_req_data[ADDR_W-1:0]));
                end else begin
                    release_and_merge(i_req_data[2*ADDR_W-1:ADDR_W]);
                    expected_responses.push_back('{status: ST_FREED, payload: '0});
                end
            end
        end
        o_pending   <= expected_responses.size();
        o_err_count <= mismatches;
    end

endmodule

FILE: verif/tb.sv
// Top of the first_fit_tag_allocator_core testbench: clock, reset, request and
// response stream drivers and the final verdict. Depends on ffta_pkg, the core
// and ffta_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffta_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [REQ_W-1:0]      i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [9:0] size_units, [19:10] block_addr
    logic                  s_axis_tuser;   // [0] cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [9:0] payload_addr
    logic [1:0]            m_axis_tuser;   // [1:0] status

    int                err_count;
    int                pending;
    int                stall_cycles = 0;
    bit                tx_idle_en   = 1'b1;
    bit                rx_idle_en   = 1'b1;
    logic [ADDR_W-1:0] live_blocks [$];

    first_fit_tag_allocator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ffta_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_data  (m_axis_tdata),
        .i_rsp_user  (m_axis_tuser),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // track granted blocks so that most frees hit live blocks
    always @(negedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready && t_status'(m_axis_tuser) == ST_GRANTED)
            live_blocks.push_back(m_axis_tdata[ADDR_W-1:0]);
    end

    initial begin
        forever begin
            if (rx_idle_en && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    task automatic send_item(input t_cmd cmd, input logic [ADDR_W-1:0] size,
                             input logic [ADDR_W-1:0] addr);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({addr, size});
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_responses();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_max_request(input logic [REQ_W-1:0] value);
        drain_responses();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int                pick;
        int                idx;
        logic [ADDR_W-1:0] size;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                case ($urandom_range(0, 9))
                    0: begin
                        size = $urandom_range(0, 1023);
                    end
                    1, 2: begin
                        size = $urandom_range(32, 255);
                    end
                    default: begin
                        size = $urandom_range(0, 31);
                    end
                endcase
                send_item(CMD_ALLOC, size, ADDR_W'($urandom));
            end else if (pick < 92 && live_blocks.size() != 0) begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                send_item(CMD_FREE, ADDR_W'($urandom), live_blocks[idx]);
                live_blocks.delete(idx);
            end else begin
                send_item(CMD_FREE, ADDR_W'($urandom), ADDR_W'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_ALLOC;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_max_request(MAX_REQ_RESET);
        send_item(CMD_ALLOC, 10'd1023, 10'd0);     // whole pool, exact fit
        send_item(CMD_ALLOC, 10'd0,    10'd1023);  // pool full
        send_item(CMD_FREE,  10'd1023, 10'd1);
        send_item(CMD_FREE,  10'd0,    10'd1);     // already free
        send_item(CMD_FREE,  10'd0,    10'd0);     // address zero
        send_item(CMD_ALLOC, 10'd0,    10'd0);
        send_item(CMD_ALLOC, 10'd9,    10'd0);
        send_item(CMD_ALLOC, 10'd4,    10'd0);
        send_item(CMD_ALLOC, 10'd19,   10'd0);
        send_item(CMD_FREE,  10'd0,    10'd2);     // merge stops at used block
        send_item(CMD_ALLOC, 10'd20,   10'd0);     // skip free block too small
        send_item(CMD_ALLOC, 10'd8,    10'd0);     // remainder of one, no split
        send_item(CMD_FREE,  10'd0,    10'd512);   // inside a block
        send_item(CMD_FREE,  10'd0,    10'd37);    // merge to pool end
        send_item(CMD_FREE,  10'd0,    10'd17);
        send_item(CMD_ALLOC, 10'd1023, 10'd0);     // fragmented, no space
        send_item(CMD_FREE,  10'd0,    10'd1023);

        set_max_request(REQ_W'(2));
        send_item(CMD_ALLOC, 10'd1,    10'd0);
        send_item(CMD_ALLOC, 10'd2,    10'd0);     // too large
        send_item(CMD_ALLOC, 10'd1023, 10'd0);
        send_item(CMD_FREE,  10'd0,    10'd17);

        set_max_request(MAX_REQ_RESET);
        run_random(120);
        set_max_request(REQ_W'(1023));
        run_random(100);
        set_max_request(REQ_W'($urandom_range(2, 1024)));
        run_random(100);
        set_max_request(REQ_W'(2));
        run_random(30);
        set_max_request(MAX_REQ_RESET);
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        run_random(150);

        drain_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
